/* rtl/core/tarc_pkg.sv */
package tarc_pkg;

  // Config register file geometry
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_TICKS = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_S  = 8'd3;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] RST_SETTLE_TICKS = 8'd1;
  localparam logic [CFG_DATA_W-1:0] RST_HOLD_TICKS   = 8'd10;
  localparam logic [CFG_DATA_W-1:0] RST_REPEAT_TICKS = 8'd2;
  localparam logic [CFG_DATA_W-1:0] RST_TICKS_PER_S  = 8'd20;

  typedef enum logic [2:0] {
    ST_START    = 3'd0,
    ST_INIT     = 3'd1,
    ST_WAIT     = 3'd2,
    ST_SETTLE   = 3'd3,
    ST_HOLD     = 3'd4,
    ST_RATE_RUN = 3'd5,
    ST_RATE_EXP = 3'd6
  } state_e;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] settle_ticks;
    logic [CFG_DATA_W-1:0] hold_ticks;
    logic [CFG_DATA_W-1:0] repeat_ticks;
    logic [CFG_DATA_W-1:0] ticks_per_second;
  } cfg_t;

  typedef struct packed {
    logic       advance_second;
    logic       inc_dec;
    logic       clear_touch;
    logic [2:0] state_code;
  } result_t;

endpackage

/* rtl/core/tarc_cfg.sv */
module tarc_cfg
  import tarc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Out-of-range indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_ticks     <= RST_SETTLE_TICKS;
      cfg_q.hold_ticks       <= RST_HOLD_TICKS;
      cfg_q.repeat_ticks     <= RST_REPEAT_TICKS;
      cfg_q.ticks_per_second <= RST_TICKS_PER_S;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SETTLE_TICKS: cfg_q.settle_ticks     <= cfg_data_i;
        REG_HOLD_TICKS:   cfg_q.hold_ticks       <= cfg_data_i;
        REG_REPEAT_TICKS: cfg_q.repeat_ticks     <= cfg_data_i;
        REG_TICKS_PER_S:  cfg_q.ticks_per_second <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/tarc_step.sv */
module tarc_step
  import tarc_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 8
) (
  input  state_e                state_i,
  input  logic [COUNT_BITS-1:0] settle_cnt_i,
  input  logic [COUNT_BITS-1:0] hold_cnt_i,
  input  logic [COUNT_BITS-1:0] rate_cnt_i,
  input  logic [COUNT_BITS-1:0] prescale_i,
  input  logic                  touched_i,
  input  cfg_t                  cfg_i,
  output state_e                state_o,
  output logic [COUNT_BITS-1:0] settle_cnt_o,
  output logic [COUNT_BITS-1:0] hold_cnt_o,
  output logic [COUNT_BITS-1:0] rate_cnt_o,
  output logic [COUNT_BITS-1:0] prescale_o,
  output result_t               result_o
);

  localparam int unsigned CmpW = (COUNT_BITS > CFG_DATA_W) ? COUNT_BITS : CFG_DATA_W;
  localparam logic [COUNT_BITS-1:0] CntMax = {COUNT_BITS{1'b1}};

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    sat_inc = (c == CntMax) ? c : c + 1'b1;
  endfunction

  // Done once the count reaches the limit or pins at saturation
  function automatic logic expired(input logic [COUNT_BITS-1:0] c,
                                   input logic [CFG_DATA_W-1:0] lim);
    expired = (CmpW'(c) >= CmpW'(lim)) || (c == CntMax);
  endfunction

  always_comb begin
    state_o      = state_i;
    settle_cnt_o = settle_cnt_i;
    hold_cnt_o   = hold_cnt_i;
    rate_cnt_o   = rate_cnt_i;
    prescale_o   = prescale_i;
    result_o     = '0;

    case (state_i)
      ST_START: begin
        state_o = ST_INIT;
      end
      ST_INIT: begin
        state_o = touched_i ? ST_WAIT : ST_INIT;
      end
      ST_WAIT: begin
        settle_cnt_o = '0;
        hold_cnt_o   = '0;
        rate_cnt_o   = '0;
        prescale_o   = sat_inc(prescale_i);
        if (expired(prescale_o, cfg_i.ticks_per_second)) begin
          result_o.advance_second = 1'b1;
          prescale_o              = '0;
        end
        if (touched_i) begin
          state_o              = ST_SETTLE;
          result_o.clear_touch = 1'b1;
        end
      end
      ST_SETTLE: begin
        settle_cnt_o = sat_inc(settle_cnt_i);
        if (expired(settle_cnt_o, cfg_i.settle_ticks)) begin
          if (touched_i) begin
            state_o = ST_HOLD;
          end else begin
            state_o          = ST_WAIT;
            result_o.inc_dec = 1'b1;
          end
        end
      end
      ST_HOLD: begin
        hold_cnt_o = sat_inc(hold_cnt_i);
        if (!touched_i) begin
          state_o          = ST_WAIT;
          result_o.inc_dec = 1'b1;
        end else if (expired(hold_cnt_o, cfg_i.hold_ticks)) begin
          state_o          = ST_RATE_RUN;
          result_o.inc_dec = 1'b1;
        end
      end
      ST_RATE_RUN: begin
        rate_cnt_o = sat_inc(rate_cnt_i);
        if (!touched_i) begin
          state_o = ST_WAIT;
        end else if (expired(rate_cnt_o, cfg_i.repeat_ticks)) begin
          state_o = ST_RATE_EXP;
        end
      end
      ST_RATE_EXP: begin
        rate_cnt_o = '0;
        if (touched_i) begin
          state_o          = ST_RATE_RUN;
          result_o.inc_dec = 1'b1;
        end else begin
          state_o = ST_WAIT;
        end
      end
      default: begin
        state_o = ST_START;
      end
    endcase

    result_o.state_code = state_o;
  end

endmodule

/* rtl/core/touch_auto_repeat_controller_core.sv */
// Touch auto-repeat (typematic) controller.
// Input channel: one transfer per tick, carrying the sampled touch level on
// touched_i. Every accepted tick yields exactly one result transfer with the
// advance_second, inc_dec and clear_touch pulses and the state after the tick.
// Latency: the result is valid the cycle after the input transfer.
// Throughput: one tick per clock unless the output stalls; the whole update is
// a single pass of the step logic between the state and output registers.
// Stall: the output register holds the pending result; a new tick is taken in
// the same cycle the old result leaves, so in_ready_o = !out_valid || ready.
// While the receiver stalls with a result pending, input is back-pressured.
// Config port: always ready, index 0..3 = settle, hold, repeat, ticks/second;
// other indexes are ignored. Write only while the block is idle.
// Reset: state returns to start, all counters and the seconds prescaler clear,
// registers return to 1, 10, 2, 20, and no result is pending.
module touch_auto_repeat_controller_core
  import tarc_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // tick input
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  touched_i,
  // result output
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  advance_second_o,
  output logic                  inc_dec_o,
  output logic                  clear_touch_o,
  output logic [2:0]            state_code_o,
  // config write
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg;

  // Controller state
  state_e                state_q, state_d;
  logic [COUNT_BITS-1:0] settle_cnt_q, settle_cnt_d;
  logic [COUNT_BITS-1:0] hold_cnt_q, hold_cnt_d;
  logic [COUNT_BITS-1:0] rate_cnt_q, rate_cnt_d;
  logic [COUNT_BITS-1:0] prescale_q, prescale_d;

  // Output register
  logic    out_valid_q;
  result_t result_q, result_d;

  logic in_xfer;

  tarc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tarc_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .state_i      (state_q),
    .settle_cnt_i (settle_cnt_q),
    .hold_cnt_i   (hold_cnt_q),
    .rate_cnt_i   (rate_cnt_q),
    .prescale_i   (prescale_q),
    .touched_i    (touched_i),
    .cfg_i        (cfg),
    .state_o      (state_d),
    .settle_cnt_o (settle_cnt_d),
    .hold_cnt_o   (hold_cnt_d),
    .rate_cnt_o   (rate_cnt_d),
    .prescale_o   (prescale_d),
    .result_o     (result_d)
  );

  // Take a tick whenever the output slot is empty or draining this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_START;
      settle_cnt_q <= '0;
      hold_cnt_q   <= '0;
      rate_cnt_q   <= '0;
      prescale_q   <= '0;
    end else if (in_xfer) begin
      state_q      <= state_d;
      settle_cnt_q <= settle_cnt_d;
      hold_cnt_q   <= hold_cnt_d;
      rate_cnt_q   <= rate_cnt_d;
      prescale_q   <= prescale_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload needs no reset; qualified by out_valid_q
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign advance_second_o = result_q.advance_second;
  assign inc_dec_o        = result_q.inc_dec;
  assign clear_touch_o    = result_q.clear_touch;
  assign state_code_o     = result_q.state_code;

endmodule

/* rtl/core/tarc_checker.sv */
module tarc_checker
  import tarc_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic                  advance_second_o,
  input logic                  inc_dec_o,
  input logic                  clear_touch_o,
  input logic [2:0]            state_code_o
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable({advance_second_o, inc_dec_o, clear_touch_o, state_code_o}))
    else $error("stalled result changed");

  // Every input transfer shows up as a result next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("input transfer produced no result");

  // Clear-touch only on the way into settle
  a_clr_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clear_touch_o |-> state_code_o == ST_SETTLE)
    else $error("clear_touch outside settle entry");

  // Inc/dec only lands in idle-wait or rate running
  a_incdec_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && inc_dec_o |->
      state_code_o == ST_WAIT || state_code_o == ST_RATE_RUN)
    else $error("inc_dec with unexpected state");

  // Advance pulse only comes from idle-wait
  a_adv_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && advance_second_o |->
      state_code_o == ST_WAIT || state_code_o == ST_SETTLE)
    else $error("advance_second outside idle-wait");

endmodule

bind touch_auto_repeat_controller_core tarc_checker u_tarc_checker (.*);
